[rtl/core/pftbp_pkg.sv]
package pftbp_pkg;

  // fixed field widths
  localparam int FLOW_IDX_BITS = 10;
  localparam int COST_BITS     = 16;
  localparam int NOW_BITS      = 48;
  localparam int LEVEL_BITS    = 16;
  localparam int INTERVAL_BITS = 32;
  localparam int VERDICT_BITS  = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam int S_DATA_BITS = 80;
  localparam int M_DATA_BITS = 24;

  // defaults for the top level parameters
  localparam int DEF_FLOW_COUNT = 1024;
  localparam int DEF_TIME_BITS  = 48;

  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 32'd1000000;
  localparam logic [LEVEL_BITS-1:0]    BURST_RESET    = 16'd0;

  // width of the index reduction step counter
  localparam int RED_CNT_W = 4;

  typedef enum logic [VERDICT_BITS-1:0] {
    VERDICT_ACCEPT   = 3'd0,
    VERDICT_OVER     = 3'd1,
    VERDICT_DISABLED = 3'd2,
    VERDICT_TOOBIG   = 3'd3,
    VERDICT_FREE     = 3'd4
  } verdict_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_BURST    = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_REFILL,
    ST_DONE
  } state_e;

  // number of compare-and-subtract steps that bring a flow index below the flow count
  function automatic int red_steps(input int flows);
    int n;
    n = 0;
    if (flows < (1 << FLOW_IDX_BITS)) begin
      while ((flows << n) < (1 << FLOW_IDX_BITS)) begin
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

[rtl/core/per_flow_token_bucket_policer_core.sv]
// Per-flow token bucket policer. Each request word names a flow, a cost in tokens and the
// current microsecond time; one result word comes back per request with accepted, a verdict
// and the tokens left in the bucket (zero for disabled, free and oversized requests). One
// request is worked on at a time. A request that refills an existing bucket passes through the
// restoring divider, which forms elapsed / interval_us one quotient bit a cycle; disabled,
// free, oversized and first-use requests skip the divider. When FLOW_COUNT is below 1024 the
// flow index is first reduced modulo FLOW_COUNT by compare-and-subtract steps. After reset
// the bucket table is swept clear, one entry a cycle, and no request is taken until the
// sweep ends; configuration writes are taken at any time but are meant to be made while the
// block is idle.
module per_flow_token_bucket_policer_core #(
  parameter int FLOW_COUNT = pftbp_pkg::DEF_FLOW_COUNT,
  parameter int TIME_BITS  = pftbp_pkg::DEF_TIME_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pftbp_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [pftbp_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // flow_index, cost, now_us, zero fill
  input  logic [pftbp_pkg::S_DATA_BITS-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // accepted, verdict, tokens_left, zero fill
  output logic [pftbp_pkg::M_DATA_BITS-1:0]   m_axis_tdata
);
  import pftbp_pkg::*;

  localparam int ADDR_W    = $clog2(FLOW_COUNT);
  localparam int ENTRY_W   = TIME_BITS + LEVEL_BITS + 1;
  localparam int RED_STEPS = red_steps(FLOW_COUNT);
  localparam logic [FLOW_IDX_BITS:0] F_RED =
    (FLOW_COUNT < (1 << FLOW_IDX_BITS)) ? (FLOW_IDX_BITS + 1)'(FLOW_COUNT) : '0;

  // configuration
  logic [INTERVAL_BITS-1:0] interval_q;
  logic [LEVEL_BITS-1:0]    burst_q;

  // request
  logic [FLOW_IDX_BITS-1:0] red_q, red_d;
  logic [RED_CNT_W-1:0]     red_cnt_q, red_cnt_d;
  logic [COST_BITS-1:0]     cost_q;
  logic [TIME_BITS-1:0]     now_q;

  // working values
  logic [LEVEL_BITS-1:0] level_q;
  logic [TIME_BITS-1:0]  stamp_new_q;
  logic                  touch_q;
  verdict_e              res_verdict_q;
  logic                  res_accept_q;

  // result register
  logic                  m_valid_q, m_valid_d;
  logic                  m_accept_q;
  verdict_e              m_verdict_q;
  logic [LEVEL_BITS-1:0] m_left_q;

  state_e state_q, state_d;

  // control
  logic take;
  logic in_ready;
  logic mem_rd_en;
  logic mem_wr_en;
  logic div_start;
  logic out_load;
  logic out_free;

  // memory and divider
  logic [ADDR_W-1:0]        flow_addr;
  logic [ENTRY_W-1:0]       rd_data;
  logic [ENTRY_W-1:0]       wr_data;
  logic                     mem_clearing;
  logic                     rd_valid;
  logic [TIME_BITS-1:0]     rd_stamp;
  logic [LEVEL_BITS-1:0]    rd_level;
  logic                     div_done;
  logic [TIME_BITS-1:0]     quotient;
  logic [INTERVAL_BITS-1:0] remainder;
  logic [TIME_BITS-1:0]     elapsed;

  // decisions
  logic                   disabled;
  logic                   free_req;
  logic                   too_big;
  logic [FLOW_IDX_BITS:0] red_sub;
  logic                   red_ge;
  logic                   q_big;
  logic [LEVEL_BITS:0]    refill_sum;
  logic                   fits;
  logic                   fin_accept;
  verdict_e               fin_verdict;
  logic [LEVEL_BITS-1:0]  fin_left;

  assign take     = s_axis_tvalid & in_ready;
  assign out_free = ~m_valid_q | m_axis_tready;

  assign disabled = (interval_q == '0) || (burst_q == '0);
  assign free_req = cost_q == '0;
  assign too_big  = cost_q > burst_q;

  assign flow_addr = ADDR_W'(red_q);
  assign rd_valid  = rd_data[ENTRY_W-1];
  assign rd_stamp  = rd_data[LEVEL_BITS +: TIME_BITS];
  assign rd_level  = rd_data[LEVEL_BITS-1:0];
  assign elapsed   = now_q - rd_stamp;

  // index reduction: subtract FLOW_COUNT shifted by the step count when it fits
  assign red_sub = F_RED << red_cnt_q;
  assign red_ge  = {1'b0, red_q} >= red_sub;

  // refill: tokens at or above the burst size saturate whatever the level
  assign q_big      = |quotient[TIME_BITS-1:LEVEL_BITS];
  assign refill_sum = {1'b0, quotient[LEVEL_BITS-1:0]} + {1'b0, level_q};

  assign fits = cost_q <= level_q;

  always_comb begin
    if (touch_q) begin
      fin_accept  = fits;
      fin_verdict = fits ? VERDICT_ACCEPT : VERDICT_OVER;
      fin_left    = fits ? (level_q - cost_q) : level_q;
    end else begin
      fin_accept  = res_accept_q;
      fin_verdict = res_verdict_q;
      fin_left    = '0;
    end
  end

  assign wr_data = {1'b1, stamp_new_q, fin_left};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (!mem_clearing) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          state_d = (RED_STEPS > 0) ? ST_REDUCE : ST_READ;
        end
      end
      ST_REDUCE: begin
        if (red_cnt_q == '0) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (disabled || free_req || too_big || !rd_valid) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_REFILL;
        end
      end
      ST_REFILL: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_rd_en = 1'b0;
    mem_wr_en = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_READ: begin
        mem_rd_en = 1'b1;
      end
      ST_CHECK: begin
        div_start = ~(disabled | free_req | too_big) & rd_valid;
      end
      ST_DONE: begin
        out_load  = out_free;
        mem_wr_en = out_free & touch_q;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    red_d     = red_q;
    red_cnt_d = red_cnt_q;
    if (take) begin
      red_d     = s_axis_tdata[FLOW_IDX_BITS-1:0];
      red_cnt_d = RED_CNT_W'(RED_STEPS - 1);
    end else if (state_q == ST_REDUCE) begin
      if (red_ge) begin
        red_d = red_q - red_sub[FLOW_IDX_BITS-1:0];
      end
      red_cnt_d = red_cnt_q - RED_CNT_W'(1);
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      m_valid_q  <= 1'b0;
      interval_q <= INTERVAL_RESET;
      burst_q    <= BURST_RESET;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_INTERVAL: interval_q <= cfg_wdata_i[INTERVAL_BITS-1:0];
          CFG_BURST:    burst_q    <= cfg_wdata_i[LEVEL_BITS-1:0];
          default:      interval_q <= interval_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    red_q     <= red_d;
    red_cnt_q <= red_cnt_d;
    if (take) begin
      cost_q <= s_axis_tdata[FLOW_IDX_BITS +: COST_BITS];
      now_q  <= TIME_BITS'(s_axis_tdata[FLOW_IDX_BITS + COST_BITS +: NOW_BITS]);
    end
    if (state_q == ST_CHECK) begin
      if (disabled) begin
        res_accept_q  <= 1'b0;
        res_verdict_q <= VERDICT_DISABLED;
        touch_q       <= 1'b0;
      end else if (free_req) begin
        res_accept_q  <= 1'b1;
        res_verdict_q <= VERDICT_FREE;
        touch_q       <= 1'b0;
      end else begin
        res_accept_q  <= 1'b0;
        res_verdict_q <= VERDICT_TOOBIG;
        touch_q       <= ~too_big;
      end
      // first use of a flow starts full, stamped now
      if (rd_valid) begin
        level_q <= rd_level;
      end else begin
        level_q     <= burst_q;
        stamp_new_q <= now_q;
      end
    end
    if (state_q == ST_REFILL) begin
      level_q <= (q_big || (refill_sum >= {1'b0, burst_q})) ? burst_q
                                                            : refill_sum[LEVEL_BITS-1:0];
      // stamp plus tokens times interval equals now minus the remainder
      stamp_new_q <= now_q - TIME_BITS'(remainder);
    end
    if (out_load) begin
      m_accept_q  <= fin_accept;
      m_verdict_q <= fin_verdict;
      m_left_q    <= fin_left;
    end
  end

  pftbp_bucket_mem #(
    .FLOW_COUNT (FLOW_COUNT),
    .ENTRY_W    (ENTRY_W),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (mem_rd_en),
    .rd_addr_i  (flow_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (mem_wr_en),
    .wr_addr_i  (flow_addr),
    .wr_data_i  (wr_data),
    .clearing_o (mem_clearing)
  );

  pftbp_divider #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (elapsed),
    .divisor_i   (interval_q),
    .done_o      (div_done),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_DATA_BITS - 1 - VERDICT_BITS - LEVEL_BITS){1'b0}},
                          m_left_q, m_verdict_q, m_accept_q};

`ifndef SYNTH
  // no request is taken while the table sweep is running
  a_no_take_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_clearing |-> !s_axis_tready)
    else $error("request taken during table clear");

  // a result never overwrites one that has not been taken
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready))
    else $error("result overwritten");

  // the table is written only for requests that reached the bucket
  a_write_only_touched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> (state_q == ST_DONE) && touch_q && !disabled && !free_req && !too_big)
    else $error("table written for an untouched request");

  // an accepted word always carries an accepting verdict
  a_accept_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_accept_q) |->
      (m_verdict_q == VERDICT_ACCEPT || m_verdict_q == VERDICT_FREE))
    else $error("accepted flag disagrees with verdict");
`endif

endmodule

[rtl/core/pftbp_bucket_mem.sv]
module pftbp_bucket_mem #(
  parameter int FLOW_COUNT = pftbp_pkg::DEF_FLOW_COUNT,
  parameter int ENTRY_W    = pftbp_pkg::DEF_TIME_BITS + pftbp_pkg::LEVEL_BITS + 1,
  parameter int ADDR_W     = $clog2(FLOW_COUNT)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [ENTRY_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [ENTRY_W-1:0] wr_data_i,
  output logic              clearing_o
);
  import pftbp_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FLOW_COUNT - 1);

  logic [ENTRY_W-1:0] mem [FLOW_COUNT];
  logic [ENTRY_W-1:0] rd_data_q;
  logic [ADDR_W-1:0]  clr_addr_q, clr_addr_d;
  logic               clearing_q, clearing_d;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;

  // sweep after reset writes every entry as not valid
  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == LAST_ADDR) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clearing_q <= clearing_d;
    end
  end

  assign we    = clearing_q | wr_en_i;
  assign waddr = clearing_q ? clr_addr_q : wr_addr_i;
  assign wdata = clearing_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

[rtl/core/pftbp_divider.sv]
module pftbp_divider #(
  parameter int TIME_BITS = pftbp_pkg::DEF_TIME_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [TIME_BITS-1:0]                dividend_i,
  input  logic [pftbp_pkg::INTERVAL_BITS-1:0] divisor_i,
  output logic                                done_o,
  output logic [TIME_BITS-1:0]                quotient_o,
  output logic [pftbp_pkg::INTERVAL_BITS-1:0] remainder_o
);
  import pftbp_pkg::*;

  localparam int CNT_W = $clog2(TIME_BITS + 1);

  logic [INTERVAL_BITS-1:0] rem_q, rem_d;
  logic [TIME_BITS-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [INTERVAL_BITS:0]   trial;
  logic [INTERVAL_BITS:0]   diff;
  logic                     ge;

  // restoring division, one quotient bit per cycle; dividend bits shift out of the top
  // of quo_q while quotient bits shift in at the bottom
  assign trial = {rem_q, quo_q[TIME_BITS-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(TIME_BITS);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d = ge ? diff[INTERVAL_BITS-1:0] : trial[INTERVAL_BITS-1:0];
      quo_d = {quo_q[TIME_BITS-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
